// ===== rtl/ffwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filament flow window monitor package
// Shared types and constants: word kinds, divider request and response,
// and the layout of one bucket entry in the bucket memory.
// ----------------------------------------------------------------------------
package ffwm_pkg;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_PULSE  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  localparam int DIV_W  = 48;
  localparam int DVSR_W = 32;

  localparam logic [31:0] U32_MAX    = 32'hFFFF_FFFF;
  localparam logic [14:0] RATIO_MAX  = 15'd24576;
  localparam logic [31:0] MIN_DUR_MS = 32'd250;
  localparam logic [15:0] MS_PER_S   = 16'd1000;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
  } div_rsp_t;

  typedef struct packed {
    logic [31:0] start_ms;
    logic [31:0] act_um;
    logic [31:0] exp_um;
  } bucket_t;

endpackage

// ===== rtl/ffwm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffwm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ffwm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module ffwm_div (
  input  logic               clk,
  input  logic               rst,
  input  ffwm_pkg::div_req_t req,
  output ffwm_pkg::div_rsp_t rsp
);
  import ffwm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  quot;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic [DVSR_W:0]   shifted;
  logic [DVSR_W:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {rem, quot[DIV_W-1]};
    diff    = shifted - {1'b0, dvsr};
    ge      = shifted >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= req.dividend;
        rem  <= '0;
        dvsr <= req.divisor;
      end else if (busy) begin
        quot <= {quot[DIV_W-2:0], ge};
        rem  <= ge ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quot: quot};

endmodule

// ===== rtl/filament_flow_window_monitor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filament flow window monitor
// Sliding-window comparison of commanded extrusion against sensor travel.
// ----------------------------------------------------------------------------
// One word is worked on at a time and every word returns one result word.
// The buckets live in a single-port-read RAM and are summed by a walk over
// all of them after a setup state. The bucket slot and index come from
// a reciprocal multiplication by a constant with one correction step;
// the ratio and both rates share one serial divider. A clear, and a
// pulse or tick before the first update, go straight to the result; a tick
// takes one walk and three divider passes (the ratio pass is skipped when
// the expected sum is at most 1 um), and an update up to two walks, a
// bucket write and three passes. A result may also wait for the output
// register, which lets the next word be taken while that result still
// waits.
module filament_flow_window_monitor_core #(
  parameter int BUCKETS   = 8,
  parameter int BUCKET_MS = 250,
  parameter int WINDOW_MS = 2000
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,   // grace_period_ms
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,     // now_ms, extrusion_total_um, pulse_um
  input  logic [1:0]   s_tuser,     // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  // window_expected_um, window_actual_um, deficit_um, flow_ratio_q14,
  // expected_rate_um_s, actual_rate_um_s, one zero pad bit
  output logic [175:0] m_tdata,
  output logic [1:0]   m_tuser      // is_initialized, within_grace
);
  import ffwm_pkg::*;

  localparam int IW    = $clog2(BUCKETS);
  localparam int CNT_W = $clog2(BUCKETS + 1);
  localparam int ACC_W = 32 + CNT_W;

  // The reciprocal never overestimates and is at most one below the quotient.
  localparam int          SLOT_SH    = 32 + $clog2(BUCKET_MS + 1) - 1;
  localparam int          IDX_SH     = 32 + $clog2(BUCKETS + 1) - 1;
  localparam logic [63:0] SLOT_RCP_W = ((64'd1 << SLOT_SH) - 64'd1) / 64'(BUCKET_MS);
  localparam logic [63:0] IDX_RCP_W  = ((64'd1 << IDX_SH) - 64'd1) / 64'(BUCKETS);
  localparam logic [31:0] SLOT_RCP   = SLOT_RCP_W[31:0];
  localparam logic [31:0] IDX_RCP    = IDX_RCP_W[31:0];

  typedef enum logic [3:0] {
    ST_IDLE, ST_APPLY, ST_WALK_SETUP, ST_WALK, ST_ADJUST, ST_SLOT_DIV,
    ST_IDX_DIV, ST_BK_RD, ST_BK_WR, ST_RATIO_DIV, ST_ERATE_DIV,
    ST_ARATE_DIV, ST_RESULT
  } state_t;

  state_t              state;
  kind_t               kind;
  logic [31:0]         now_ms;
  logic signed [31:0]  ext_total;
  logic [15:0]         pulse_um;
  logic [31:0]         grace_period;
  logic                init_flag;
  logic signed [31:0]  last_ext;
  logic [31:0]         sensor_total;
  logic [31:0]         sensor_at_upd;
  logic [31:0]         last_upd_ms;
  logic [BUCKETS-1:0]  valid;
  logic                walk_out;
  logic                add_pulse;
  logic [31:0]         add_val;
  logic [31:0]         slot;
  logic [31:0]         start_ms;
  logic [IW-1:0]       idx;
  logic [CNT_W-1:0]    cnt;
  logic                pend;
  logic [IW-1:0]       widx;
  logic [ACC_W-1:0]    e_acc;
  logic [ACC_W-1:0]    a_acc;
  logic [CNT_W-1:0]    n_cnt;
  logic [31:0]         dur;
  logic [14:0]         ratio;
  logic [31:0]         er;
  logic [31:0]         ar;
  logic                div_busy;
  logic [1:0]          cd_step;
  logic [63:0]         cd_prod;
  logic [31:0]         cd_q;
  logic [31:0]         cd_r;

  logic [31:0] o_we, o_wa, o_def, o_er, o_ar;
  logic [14:0] o_ratio;
  logic        o_init, o_grace;

  bucket_t             rd_entry, entry, wr_entry;
  logic [IW-1:0]       raddr;
  logic                ram_we;
  logic [31:0]         cutoff;
  logic                in_win;
  logic [31:0]         we_sat, wa_sat;
  logic [31:0]         since, orphan;
  logic signed [33:0]  delta, adj;
  logic [32:0]         bsum;
  logic [32:0]         tsum;
  logic [31:0]         bk_old;
  logic                grace_hit;
  logic [31:0]         dur_raw;
  logic                div_phase;
  logic                cd_slot;
  logic [31:0]         cd_x, cd_rcp, cd_d, cd_q_est, cd_q_fix, cd_r_fix;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  ffwm_ram #(.WIDTH($bits(bucket_t)), .DEPTH(BUCKETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  ffwm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    raddr  = (state == ST_WALK) ? cnt[IW-1:0] : idx;
    entry  = valid[(state == ST_WALK) ? widx : idx] ? rd_entry : '0;
    cutoff = (now_ms < 32'(WINDOW_MS)) ? 32'd0 : now_ms - 32'(WINDOW_MS);
    in_win = (entry.start_ms >= cutoff) && (entry.start_ms <= now_ms);
    we_sat = (|e_acc[ACC_W-1:32]) ? U32_MAX : e_acc[31:0];
    wa_sat = (|a_acc[ACC_W-1:32]) ? U32_MAX : a_acc[31:0];

    since  = (sensor_total >= sensor_at_upd) ? sensor_total - sensor_at_upd : 32'd0;
    orphan = (since > wa_sat) ? since - wa_sat : 32'd0;
    delta  = {{2{ext_total[31]}}, ext_total} - {{2{last_ext[31]}}, last_ext};
    adj    = delta - $signed({2'b00, orphan});

    tsum   = {1'b0, sensor_total} + {17'd0, pulse_um};

    // A bucket whose slot start is stale is restarted before the add.
    wr_entry = entry;
    if (entry.start_ms != start_ms) begin
      wr_entry = '{start_ms: start_ms, act_um: 32'd0, exp_um: 32'd0};
    end
    bk_old   = add_pulse ? wr_entry.act_um : wr_entry.exp_um;
    bsum     = {1'b0, bk_old} + {1'b0, add_val};
    if (add_pulse) begin
      wr_entry.act_um = bsum[32] ? U32_MAX : bsum[31:0];
    end else begin
      wr_entry.exp_um = bsum[32] ? U32_MAX : bsum[31:0];
    end
    ram_we = (state == ST_BK_WR);

    dur_raw   = 32'(n_cnt) * 32'(BUCKET_MS);
    grace_hit = init_flag && (grace_period != 32'd0) &&
                ((now_ms - last_upd_ms) < grace_period);

    // Slot and index by a constant: the slot state divides the time, the
    // index state the slot.
    cd_slot  = (state == ST_SLOT_DIV);
    cd_x     = cd_slot ? now_ms : slot;
    cd_rcp   = cd_slot ? SLOT_RCP : IDX_RCP;
    cd_d     = cd_slot ? 32'(BUCKET_MS) : 32'(BUCKETS);
    cd_q_est = cd_slot ? 32'(cd_prod >> SLOT_SH) : 32'(cd_prod >> IDX_SH);
    cd_q_fix = (cd_r >= cd_d) ? cd_q + 32'd1 : cd_q;
    cd_r_fix = (cd_r >= cd_d) ? cd_r - cd_d : cd_r;

    div_phase = (state == ST_ERATE_DIV) || (state == ST_ARATE_DIV) ||
                ((state == ST_RATIO_DIV) && (we_sat > 32'd1));
    div_req.start = div_phase && !div_busy;
    case (state)
      ST_RATIO_DIV: begin
        div_req.dividend = {2'b00, wa_sat, 14'd0};
        div_req.divisor  = we_sat;
      end
      ST_ERATE_DIV: begin
        div_req.dividend = {16'd0, we_sat} * {32'd0, MS_PER_S};
        div_req.divisor  = dur;
      end
      ST_ARATE_DIV: begin
        div_req.dividend = {16'd0, wa_sat} * {32'd0, MS_PER_S};
        div_req.divisor  = dur;
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      grace_period  <= 32'd0;
      init_flag     <= 1'b0;
      last_ext      <= 32'sd0;
      sensor_total  <= 32'd0;
      sensor_at_upd <= 32'd0;
      last_upd_ms   <= 32'd0;
      valid         <= '0;
      pend          <= 1'b0;
      div_busy      <= 1'b0;
      cd_step       <= 2'd0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        grace_period <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != ST_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      if (div_req.start) begin
        div_busy <= 1'b1;
      end else if (div_rsp.done) begin
        div_busy <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind      <= kind_t'(s_tuser);
            now_ms    <= s_tdata[31:0];
            ext_total <= s_tdata[63:32];
            pulse_um  <= s_tdata[79:64];
            state     <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          walk_out <= 1'b1;
          case (kind)
            KIND_CLEAR: begin
              init_flag     <= 1'b0;
              last_ext      <= 32'sd0;
              sensor_total  <= 32'd0;
              sensor_at_upd <= 32'd0;
              last_upd_ms   <= 32'd0;
              valid         <= '0;
              state         <= ST_RESULT;
            end
            KIND_PULSE: begin
              if (pulse_um == 16'd0) begin
                state <= init_flag ? ST_WALK_SETUP : ST_RESULT;
              end else begin
                sensor_total <= tsum[32] ? U32_MAX : tsum[31:0];
                add_pulse    <= 1'b1;
                add_val      <= {16'd0, pulse_um};
                state        <= init_flag ? ST_SLOT_DIV : ST_RESULT;
              end
            end
            KIND_UPDATE: begin
              if (!init_flag) begin
                init_flag     <= 1'b1;
                last_upd_ms   <= now_ms;
                last_ext      <= ext_total;
                sensor_at_upd <= sensor_total;
              end else begin
                walk_out <= 1'b0;
              end
              state <= ST_WALK_SETUP;
            end
            default: begin
              state <= init_flag ? ST_WALK_SETUP : ST_RESULT;
            end
          endcase
        end
        ST_WALK_SETUP: begin
          cnt   <= '0;
          pend  <= 1'b0;
          e_acc <= '0;
          a_acc <= '0;
          n_cnt <= '0;
          state <= ST_WALK;
        end
        ST_WALK: begin
          // Reads are issued one per cycle; each entry is summed in the cycle after its read.
          pend <= (cnt < CNT_W'(BUCKETS));
          if (cnt < CNT_W'(BUCKETS)) begin
            widx <= cnt[IW-1:0];
            cnt  <= cnt + 1'b1;
          end
          if (pend && in_win) begin
            e_acc <= e_acc + ACC_W'(entry.exp_um);
            a_acc <= a_acc + ACC_W'(entry.act_um);
            n_cnt <= n_cnt + 1'b1;
          end
          if (!pend && (cnt == CNT_W'(BUCKETS))) begin
            state <= walk_out ? ST_RATIO_DIV : ST_ADJUST;
          end
        end
        ST_ADJUST: begin
          last_ext      <= ext_total;
          sensor_at_upd <= sensor_total;
          last_upd_ms   <= now_ms;
          walk_out      <= 1'b1;
          add_pulse     <= 1'b0;
          add_val       <= adj[31:0];
          state         <= (adj > 34'sd1) ? ST_SLOT_DIV : ST_WALK_SETUP;
        end
        ST_SLOT_DIV, ST_IDX_DIV: begin
          cd_step <= cd_step + 2'd1;
          case (cd_step)
            2'd0: begin
              cd_prod <= {32'd0, cd_x} * {32'd0, cd_rcp};
            end
            2'd1: begin
              cd_q <= cd_q_est;
            end
            2'd2: begin
              cd_r <= cd_x - cd_q * cd_d;
            end
            default: begin
              if (cd_slot) begin
                slot  <= cd_q_fix;
                state <= ST_IDX_DIV;
              end else begin
                idx   <= cd_r_fix[IW-1:0];
                state <= ST_BK_RD;
              end
            end
          endcase
        end
        ST_BK_RD: begin
          start_ms <= slot * 32'(BUCKET_MS);
          state    <= ST_BK_WR;
        end
        ST_BK_WR: begin
          valid[idx] <= 1'b1;
          state      <= ST_WALK_SETUP;
        end
        ST_RATIO_DIV: begin
          dur <= (dur_raw < MIN_DUR_MS) ? MIN_DUR_MS : dur_raw;
          if (we_sat <= 32'd1) begin
            ratio <= 15'd0;
            state <= ST_ERATE_DIV;
          end else if (div_rsp.done) begin
            ratio <= ((|div_rsp.quot[DIV_W-1:15]) || (div_rsp.quot[14:0] > RATIO_MAX))
                     ? RATIO_MAX : div_rsp.quot[14:0];
            state <= ST_ERATE_DIV;
          end
        end
        ST_ERATE_DIV: begin
          if (div_rsp.done) begin
            er    <= (|div_rsp.quot[DIV_W-1:32]) ? U32_MAX : div_rsp.quot[31:0];
            state <= ST_ARATE_DIV;
          end
        end
        ST_ARATE_DIV: begin
          if (div_rsp.done) begin
            ar    <= (|div_rsp.quot[DIV_W-1:32]) ? U32_MAX : div_rsp.quot[31:0];
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            o_init   <= init_flag;
            o_grace  <= grace_hit;
            o_we     <= init_flag ? we_sat : 32'd0;
            o_wa     <= init_flag ? wa_sat : 32'd0;
            o_def    <= (init_flag && (we_sat > wa_sat)) ? we_sat - wa_sat : 32'd0;
            o_ratio  <= init_flag ? ratio : 15'd0;
            o_er     <= init_flag ? er : 32'd0;
            o_ar     <= init_flag ? ar : 32'd0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {1'b0, o_ar, o_er, o_ratio, o_def, o_wa, o_we};
  assign m_tuser = {o_grace, o_init};

`ifndef NO_ASSERTIONS
  a_grace_needs_init: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
    else $error("grace flag set on an uninitialized result");

  a_ratio_clamped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[110:96] <= RATIO_MAX))
    else $error("flow ratio above clamp");

  a_uninit_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("uninitialized result carries nonzero data");

  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !div_busy)
    else $error("divider still busy when a new word is taken");
`endif

endmodule

// ===== tb/tb_filament_flow_window_monitor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filament flow window monitor testbench
// Drives update, pulse, tick and clear words with random gaps outside the
// quiet run, predicts each result word from an internal copy of the window
// state, and compares every field but the pad bit as the block emits it.
// ----------------------------------------------------------------------------
module tb_filament_flow_window_monitor_core;
  import ffwm_pkg::*;

  localparam int NB      = 8;
  localparam int SLOT_MS = 250;
  localparam int WIN_MS  = 2000;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_ms;
    logic [31:0] total_um;
    logic [15:0] pulse_um;
  } flow_word_t;

  typedef struct packed {
    logic [31:0] win_exp;
    logic [31:0] win_act;
    logic [31:0] deficit;
    logic [14:0] ratio;
    logic [31:0] exp_rate;
    logic [31:0] act_rate;
    logic        inited;
    logic        grace;
  } flow_status_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;   // now_ms, extrusion_total_um, pulse_um
  logic [1:0]   s_tuser = '0;   // kind
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [175:0] m_tdata;        // exp, act, deficit, ratio, exp rate, act rate, pad
  logic [1:0]   m_tuser;        // is_initialized, within_grace

  filament_flow_window_monitor_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] grace_ms;
  logic        p_init;
  logic [31:0] p_last_total;
  logic [31:0] p_sensor;
  logic [31:0] p_sensor_snap;
  logic [31:0] p_last_upd;
  logic [31:0] p_exp [NB];
  logic [31:0] p_act [NB];
  logic [31:0] p_start [NB];

  flow_word_t   pending_words [$];
  flow_status_t expected_status [$];
  int  errors = 0;
  bit  quiet = 1'b0;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [63:0] b);
    logic [63:0] s;
    s = {32'd0, a} + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_window();
    p_init = 1'b0;
    p_last_total = '0;
    p_sensor = '0;
    p_sensor_snap = '0;
    p_last_upd = '0;
    for (int i = 0; i < NB; i++) begin
      p_exp[i] = '0;
      p_act[i] = '0;
      p_start[i] = '0;
    end
  endtask

  function automatic int open_bucket(logic [31:0] now);
    logic [31:0] slot, st;
    int idx;
    slot = now / SLOT_MS;
    idx = slot % NB;
    st = slot * SLOT_MS;
    if (p_start[idx] != st) begin
      p_exp[idx] = '0;
      p_act[idx] = '0;
      p_start[idx] = st;
    end
    return idx;
  endfunction

  task automatic sum_window(input logic [31:0] now, output logic [31:0] we,
                            output logic [31:0] wa, output int n);
    logic [31:0] cutoff;
    logic [63:0] e, a;
    cutoff = (now < WIN_MS) ? 32'd0 : now - WIN_MS;
    e = 0;
    a = 0;
    n = 0;
    for (int i = 0; i < NB; i++) begin
      if (p_start[i] >= cutoff && p_start[i] <= now) begin
        e += p_exp[i];
        a += p_act[i];
        n++;
      end
    end
    we = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
    wa = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
  endtask

  task automatic predict_flow(input flow_word_t w);
    flow_status_t r;
    logic [31:0] we, wa, since;
    logic signed [63:0] delta, orphan, adj;
    logic [63:0] q, dur;
    int n, idx;
    r = '0;
    case (w.kind)
      KIND_UPDATE: begin
        if (!p_init) begin
          p_init = 1'b1;
          p_last_upd = w.now_ms;
          p_last_total = w.total_um;
          p_sensor_snap = p_sensor;
        end else begin
          delta = $signed({{32{w.total_um[31]}}, w.total_um})
                - $signed({{32{p_last_total[31]}}, p_last_total});
          since = (p_sensor >= p_sensor_snap) ? p_sensor - p_sensor_snap : 32'd0;
          sum_window(w.now_ms, we, wa, n);
          orphan = $signed({32'd0, since}) - $signed({32'd0, wa});
          if (orphan < 0) orphan = 0;
          adj = delta - orphan;
          if (adj < 0) adj = 0;
          if (adj > 1) begin
            idx = open_bucket(w.now_ms);
            p_exp[idx] = sat_add32(p_exp[idx], adj);
          end
          p_last_total = w.total_um;
          p_sensor_snap = p_sensor;
          p_last_upd = w.now_ms;
        end
      end
      KIND_PULSE: begin
        if (w.pulse_um != 0) begin
          if (p_init) begin
            idx = open_bucket(w.now_ms);
            p_act[idx] = sat_add32(p_act[idx], {48'd0, w.pulse_um});
          end
          p_sensor = sat_add32(p_sensor, {48'd0, w.pulse_um});
        end
      end
      KIND_CLEAR: clear_window();
      default: ;
    endcase
    if (p_init) begin
      sum_window(w.now_ms, we, wa, n);
      r.win_exp = we;
      r.win_act = wa;
      r.deficit = (we > wa) ? we - wa : 32'd0;
      if (we > 1) begin
        q = {wa, 14'd0} / we;
        r.ratio = (q > 24576) ? 15'd24576 : q[14:0];
      end
      dur = n * SLOT_MS;
      if (dur < 250) dur = 250;
      q = ({32'd0, we} * 1000) / dur;
      r.exp_rate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      q = ({32'd0, wa} * 1000) / dur;
      r.act_rate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      r.grace = (grace_ms != 0) && ((w.now_ms - p_last_upd) < grace_ms);
    end
    r.inited = p_init;
    expected_status.push_back(r);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  // Driver: predicts each word as it is accepted.
  flow_word_t cur;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_flow(cur);
        void'(pending_words.pop_front());
      end
      if ((!s_tvalid || s_tready) ) begin
        if ((s_tvalid && s_tready ? pending_words.size() > 0 : pending_words.size() > 0)
            && (quiet || $urandom_range(99) >= 37)) begin
          cur = pending_words[0];
          s_tvalid <= 1'b1;
          s_tdata <= {cur.pulse_um, cur.total_um, cur.now_ms};
          s_tuser <= cur.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= quiet || ($urandom_range(99) >= 37);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    flow_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected_result", 32'd1, 32'd0);
      end else begin
        want = expected_status.pop_front();
        if (m_tdata[31:0] !== want.win_exp) report_mismatch("window_expected", m_tdata[31:0], want.win_exp);
        if (m_tdata[63:32] !== want.win_act) report_mismatch("window_actual", m_tdata[63:32], want.win_act);
        if (m_tdata[95:64] !== want.deficit) report_mismatch("deficit", m_tdata[95:64], want.deficit);
        if (m_tdata[110:96] !== want.ratio) report_mismatch("flow_ratio", m_tdata[110:96], want.ratio);
        if (m_tdata[142:111] !== want.exp_rate) report_mismatch("expected_rate", m_tdata[142:111], want.exp_rate);
        if (m_tdata[174:143] !== want.act_rate) report_mismatch("actual_rate", m_tdata[174:143], want.act_rate);
        if (m_tuser[0] !== want.inited) report_mismatch("is_initialized", m_tuser[0], want.inited);
        if (m_tuser[1] !== want.grace) report_mismatch("within_grace", m_tuser[1], want.grace);
      end
    end
  end

  function automatic flow_word_t make_word(kind_t k, logic [31:0] now,
                                           logic [31:0] tot, logic [15:0] p);
    flow_word_t w;
    w.kind = k;
    w.now_ms = now;
    w.total_um = tot;
    w.pulse_um = p;
    return w;
  endfunction

  task automatic wait_idle();
    while (pending_words.size() > 0 || s_tvalid || expected_status.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_grace(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    grace_ms = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic: updates with growing totals, pulses, ticks,
  // clears, time walking forward mostly by small steps; some words are random.
  task automatic random_run(int count, logic [31:0] t0);
    logic [31:0] now, tot;
    int r;
    now = t0;
    tot = $urandom;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      now += (r < 5) ? $urandom_range(3000) : $urandom_range(120);
      if (r < 40) begin
        tot += ($urandom_range(9) == 0) ? $urandom : $urandom_range(4000);
        pending_words.push_back(make_word(KIND_UPDATE, now, tot, 16'($urandom)));
      end else if (r < 85) begin
        pending_words.push_back(make_word(KIND_PULSE, now, $urandom,
          ($urandom_range(19) == 0) ? 16'd0
                                    : (r < 50 ? 16'($urandom) : 16'($urandom_range(3000)))));
      end else if (r < 95) begin
        pending_words.push_back(make_word(KIND_TICK, now, $urandom, 16'($urandom)));
      end else if (r < 97) begin
        pending_words.push_back(make_word(KIND_CLEAR, now, $urandom, 16'($urandom)));
      end else begin
        pending_words.push_back(make_word(kind_t'($urandom_range(3)), $urandom, $urandom,
                                          16'($urandom)));
      end
    end
  endtask

  initial begin
    grace_ms = '0;
    clear_window();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_grace(32'd0);

    // Directed: pulse before init, first update, updates, pulse of zero,
    // sensor ahead of window, time wrap, extreme totals, clear.
    pending_words.push_back(make_word(KIND_TICK, 32'd0, 32'd0, 16'd0));
    pending_words.push_back(make_word(KIND_PULSE, 32'd10, 32'd0, 16'hFFFF));
    pending_words.push_back(make_word(KIND_UPDATE, 32'd20, 32'h8000_0000, 16'd0));
    pending_words.push_back(make_word(KIND_UPDATE, 32'd30, 32'h7FFF_FFFF, 16'd0));
    pending_words.push_back(make_word(KIND_UPDATE, 32'd40, 32'h8000_0000, 16'd0));
    pending_words.push_back(make_word(KIND_UPDATE, 32'd300, 32'h8000_0001, 16'd0));
    pending_words.push_back(make_word(KIND_UPDATE, 32'd310, 32'h8000_0003, 16'd0));
    pending_words.push_back(make_word(KIND_PULSE, 32'd320, 32'hFFFF_FFFF, 16'd0));
    pending_words.push_back(make_word(KIND_PULSE, 32'd330, 32'd0, 16'd1));
    pending_words.push_back(make_word(KIND_PULSE, 32'd2600, 32'd0, 16'd5000));
    pending_words.push_back(make_word(KIND_UPDATE, 32'd2700, 32'h8000_2000, 16'd0));
    pending_words.push_back(make_word(KIND_TICK, 32'd9000, 32'd0, 16'd0));
    pending_words.push_back(make_word(KIND_CLEAR, 32'd9100, 32'd0, 16'd0));
    pending_words.push_back(make_word(KIND_UPDATE, 32'hFFFF_FF00, 32'd0, 16'd0));
    pending_words.push_back(make_word(KIND_UPDATE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'd0));
    pending_words.push_back(make_word(KIND_PULSE, 32'hFFFF_FFFF, 32'd0, 16'hFFFF));
    pending_words.push_back(make_word(KIND_TICK, 32'd5, 32'd0, 16'd0));
    pending_words.push_back(make_word(KIND_CLEAR, 32'd6, 32'd0, 16'd0));
    wait_idle();

    write_grace(32'hFFFF_FFFF);
    random_run(300, $urandom);
    wait_idle();
    write_grace(32'd500);
    quiet = 1'b1;
    random_run(300, 32'd0);
    wait_idle();
    quiet = 1'b0;
    write_grace(32'd1);
    random_run(350, $urandom);
    wait_idle();
    write_grace($urandom_range(3000));
    random_run(350, 32'hFFFF_F000);
    wait_idle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ffwm_pkg.sv
rtl/ffwm_ram.sv
rtl/ffwm_div.sv
rtl/filament_flow_window_monitor_core.sv
tb/tb_filament_flow_window_monitor_core.sv
